// ----- rtl/rbdt_pkg.sv -----
// Shared types, constants and an index helper for the rigid body derived transform.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
`default_nettype none
package rbdt_pkg;

   // Fixed-point widths
   localparam int QW      = 16;              // quaternion component, Q2.14
   localparam int DW      = 32;              // Q16.16 data word
   localparam int PRODW   = 2 * QW;          // quaternion product, Q.28
   localparam int Q28W    = PRODW + 3;       // 1 - 2a - 2b, exact
   localparam int ROTW    = Q28W - 12;       // rotation entry, Q.16 after rounding
   localparam int TW      = 42;              // R*I entry, Q.16, unsaturated
   localparam int MULW    = TW + ROTW;       // shared multiplier product
   localparam int SUMW    = MULW + 2;        // sum of three products
   localparam int RNDW    = SUMW - 16;       // sum after dropping 16 fraction bits
   localparam int NUM_ROWS = 6;
   localparam int NUM_REGS = 6;

   localparam logic signed [Q28W-1:0] Q28_ONE = Q28W'(1) <<< 28;
   localparam logic signed [DW-1:0]   SAT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DW-1:0]   SAT_MIN = 32'sh8000_0000;

   // Row codes
   localparam logic [2:0] ROW_FIRST  = 3'd0;
   localparam logic [2:0] ROW_TENSOR = 3'd3;
   localparam logic [2:0] ROW_LAST   = 3'd5;

   // Register indexes of the configuration port
   typedef enum logic [2:0] {
      CSR_XX = 3'd0,
      CSR_XY = 3'd1,
      CSR_XZ = 3'd2,
      CSR_YY = 3'd3,
      CSR_YZ = 3'd4,
      CSR_ZZ = 3'd5
   } csr_index_type;

   localparam logic signed [DW-1:0] INERTIA_ONE = 32'sd65536;

   typedef struct packed {
      logic signed [QW-1:0] quat_r;
      logic signed [QW-1:0] quat_i;
      logic signed [QW-1:0] quat_j;
      logic signed [QW-1:0] quat_k;
      logic signed [DW-1:0] pos_x;
      logic signed [DW-1:0] pos_y;
      logic signed [DW-1:0] pos_z;
   } req_type;

   typedef struct packed {
      logic [2:0]           row_index;
      logic signed [DW-1:0] col0;
      logic signed [DW-1:0] col1;
      logic signed [DW-1:0] col2;
      logic signed [DW-1:0] col3;
      logic                 last_row;
   } rsp_type;

   // One queued item: rounded rotation (row major) and position
   typedef struct packed {
      logic [8:0][ROTW-1:0] rot;
      logic [2:0][DW-1:0]   pos;
   } work_type;

   // Queue status seen by the front door and the back end
   typedef struct packed {
      logic empty;
      logic no_room;
   } qstat_type;

   // Register index of symmetric tensor entry (row, col)
   function automatic logic [2:0] sym_index(input int unsigned row, input int unsigned col);
      logic [2:0] idx;
      if (row == col) begin
         idx = (row == 0) ? CSR_XX : (row == 1) ? CSR_YY : CSR_ZZ;
      end else if (row + col == 1) begin
         idx = CSR_XY;
      end else if (row + col == 2) begin
         idx = CSR_XZ;
      end else begin
         idx = CSR_YZ;
      end
      return idx;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/rbdt_front.sv -----
// Front end: takes the quaternion, forms its products and the rounded rotation matrix.
// Depends on rbdt_pkg.
`default_nettype none
module rbdt_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              take,
   input  wire rbdt_pkg::req_type item,
   output logic                   push,
   output rbdt_pkg::work_type     push_data
);

   logic signed [rbdt_pkg::PRODW-1:0] prod_ff [9];
   logic signed [rbdt_pkg::PRODW-1:0] prod_in [9];
   logic [2:0][rbdt_pkg::DW-1:0]      pos_ff;
   logic                              valid_ff;
   logic signed [rbdt_pkg::Q28W-1:0]  q28 [9];
   logic signed [rbdt_pkg::Q28W-1:0]  rnd [9];

   function automatic logic signed [rbdt_pkg::Q28W-1:0] dbl(
         input logic signed [rbdt_pkg::PRODW-1:0] p);
      logic signed [rbdt_pkg::Q28W-1:0] w;
      w = {{(rbdt_pkg::Q28W - rbdt_pkg::PRODW){p[rbdt_pkg::PRODW-1]}}, p};
      return w <<< 1;
   endfunction

   // Form the nine quaternion products: ii jj kk ij ik jk ri rj rk
   always_comb begin
      prod_in[0] = item.quat_i * item.quat_i;
      prod_in[1] = item.quat_j * item.quat_j;
      prod_in[2] = item.quat_k * item.quat_k;
      prod_in[3] = item.quat_i * item.quat_j;
      prod_in[4] = item.quat_i * item.quat_k;
      prod_in[5] = item.quat_j * item.quat_k;
      prod_in[6] = item.quat_r * item.quat_i;
      prod_in[7] = item.quat_r * item.quat_j;
      prod_in[8] = item.quat_r * item.quat_k;
   end

   // Register the products and the position
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= take;
      end
      if (take) begin
         prod_ff   <= prod_in;
         pos_ff[0] <= item.pos_x;
         pos_ff[1] <= item.pos_y;
         pos_ff[2] <= item.pos_z;
      end
   end

   // Build the exact Q.28 matrix, round each entry to Q.16
   always_comb begin
      q28[0] = rbdt_pkg::Q28_ONE - dbl(prod_ff[1]) - dbl(prod_ff[2]);
      q28[1] = dbl(prod_ff[3]) - dbl(prod_ff[8]);
      q28[2] = dbl(prod_ff[4]) + dbl(prod_ff[7]);
      q28[3] = dbl(prod_ff[3]) + dbl(prod_ff[8]);
      q28[4] = rbdt_pkg::Q28_ONE - dbl(prod_ff[0]) - dbl(prod_ff[2]);
      q28[5] = dbl(prod_ff[5]) - dbl(prod_ff[6]);
      q28[6] = dbl(prod_ff[4]) - dbl(prod_ff[7]);
      q28[7] = dbl(prod_ff[5]) + dbl(prod_ff[6]);
      q28[8] = rbdt_pkg::Q28_ONE - dbl(prod_ff[0]) - dbl(prod_ff[1]);
      for (int n = 0; n < 9; n++) begin
         rnd[n] = q28[n] + (rbdt_pkg::Q28W'(1) <<< 11);
         push_data.rot[n] = rnd[n][rbdt_pkg::Q28W-1:12];
      end
      push_data.pos = pos_ff;
   end

   assign push = valid_ff;

endmodule
`default_nettype wire

// ----- rtl/rbdt_queue.sv -----
// Short queue between the front end and the back end.
// Depends on rbdt_pkg.
`default_nettype none
module rbdt_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire rbdt_pkg::work_type push_data,
   input  wire logic               reserve,
   input  wire logic               pop,
   output rbdt_pkg::work_type      head,
   output rbdt_pkg::qstat_type     stat
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   rbdt_pkg::work_type mem [DEPTH];
   logic [PW-1:0]      wr_ptr_ff;
   logic [PW-1:0]      rd_ptr_ff;
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;

   // Advance pointers and level
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
      end
   end

   // Store the beat
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   assign head         = mem[rd_ptr_ff];
   assign stat.empty   = (count_ff == '0);
   assign stat.no_room = ((CW+1)'(count_ff) + (CW+1)'(reserve)) >= (CW+1)'(DEPTH);

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && count_ff == CW'(DEPTH)))
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && count_ff == '0))
      else $error("queue read while empty");
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue level beyond depth");
`endif

endmodule
`default_nettype wire

// ----- rtl/rbdt_back.sv -----
// Back end: six-step sequencer with nine shared multipliers; forms R*I, then (R*I)*R^T,
// and emits the transform and tensor rows. Depends on rbdt_pkg.
`default_nettype none
module rbdt_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire rbdt_pkg::work_type            head,
   input  wire rbdt_pkg::qstat_type           stat,
   input  wire logic [5:0][rbdt_pkg::DW-1:0]  inertia,
   output logic                               pop,
   output logic                               rsp_valid,
   output rbdt_pkg::rsp_type                  rsp_item
);

   rbdt_pkg::work_type                  cur_ff;
   logic                                act_ff;
   logic [2:0]                          step_ff;
   logic signed [rbdt_pkg::MULW-1:0]    prod_ff [9];
   logic signed [rbdt_pkg::MULW-1:0]    prod_in [9];
   logic                                sd_valid_ff;
   logic [2:0]                          sd_step_ff;
   logic signed [rbdt_pkg::TW-1:0]      t_ff [9];
   logic signed [rbdt_pkg::TW-1:0]      opx  [9];
   logic signed [rbdt_pkg::ROTW-1:0]    opy  [9];
   logic signed [rbdt_pkg::SUMW-1:0]    sum  [3];
   logic signed [rbdt_pkg::RNDW-1:0]    rsum [3];
   logic signed [rbdt_pkg::DW-1:0]      sat  [3];
   logic [1:0]                          arow;
   logic [3:0]                          aidx [3];
   logic [1:0]                          srow;
   rbdt_pkg::rsp_type                   rsp_in;
   rbdt_pkg::rsp_type                   rsp_ff;
   logic                                rsp_valid_ff;

   function automatic logic signed [rbdt_pkg::SUMW-1:0] ext(
         input logic signed [rbdt_pkg::MULW-1:0] p);
      return {{(rbdt_pkg::SUMW - rbdt_pkg::MULW){p[rbdt_pkg::MULW-1]}}, p};
   endfunction

   // Take the next item when idle or once the current one reaches its last step
   assign pop = !stat.empty && (!act_ff || step_ff == rbdt_pkg::ROW_LAST);

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff  <= 1'b0;
         step_ff <= rbdt_pkg::ROW_FIRST;
      end else if (pop) begin
         act_ff  <= 1'b1;
         step_ff <= rbdt_pkg::ROW_FIRST;
      end else if (act_ff) begin
         if (step_ff == rbdt_pkg::ROW_LAST) begin
            act_ff <= 1'b0;
         end else begin
            step_ff <= step_ff + 3'd1;
         end
      end
      if (pop) begin
         cur_ff <= head;
      end
   end

   // Steer the multiplier operands: R row times I, or T row times R^T
   always_comb begin
      arow = (step_ff >= rbdt_pkg::ROW_TENSOR) ? 2'(step_ff - rbdt_pkg::ROW_TENSOR)
                                                : step_ff[1:0];
      for (int c = 0; c < 3; c++) begin
         aidx[c] = 4'(arow) * 4'd3 + 4'(c);
      end
      for (int n = 0; n < 9; n++) begin
         if (step_ff < rbdt_pkg::ROW_TENSOR) begin
            opx[n] = rbdt_pkg::TW'($signed(inertia[rbdt_pkg::sym_index(n % 3, n / 3)]));
            opy[n] = $signed(cur_ff.rot[aidx[n % 3]]);
         end else begin
            opx[n] = t_ff[aidx[n % 3]];
            opy[n] = $signed(cur_ff.rot[(n / 3) * 3 + (n % 3)]);
         end
         prod_in[n] = rbdt_pkg::MULW'(opx[n]) * rbdt_pkg::MULW'(opy[n]);
      end
   end

   // Register the nine products and the step they belong to
   always_ff @(posedge clock) begin
      if (reset) begin
         sd_valid_ff <= 1'b0;
         sd_step_ff  <= rbdt_pkg::ROW_FIRST;
      end else begin
         sd_valid_ff <= act_ff;
         sd_step_ff  <= step_ff;
      end
      prod_ff <= prod_in;
   end

   // Sum, round and saturate one row of three entries; form the response row
   always_comb begin
      srow = (sd_step_ff >= rbdt_pkg::ROW_TENSOR) ? 2'(sd_step_ff - rbdt_pkg::ROW_TENSOR)
                                                   : sd_step_ff[1:0];
      for (int b = 0; b < 3; b++) begin
         sum[b]  = ext(prod_ff[3*b]) + ext(prod_ff[3*b+1]) + ext(prod_ff[3*b+2])
                 + (rbdt_pkg::SUMW'(1) <<< 15);
         rsum[b] = sum[b][rbdt_pkg::SUMW-1:16];
         if (rsum[b] > rbdt_pkg::RNDW'(rbdt_pkg::SAT_MAX)) begin
            sat[b] = rbdt_pkg::SAT_MAX;
         end else if (rsum[b] < rbdt_pkg::RNDW'(rbdt_pkg::SAT_MIN)) begin
            sat[b] = rbdt_pkg::SAT_MIN;
         end else begin
            sat[b] = rsum[b][rbdt_pkg::DW-1:0];
         end
      end
      rsp_in.row_index = sd_step_ff;
      rsp_in.last_row  = (sd_step_ff == rbdt_pkg::ROW_LAST);
      if (sd_step_ff < rbdt_pkg::ROW_TENSOR) begin
         rsp_in.col0 = rbdt_pkg::DW'($signed(cur_ff.rot[4'(srow) * 4'd3]));
         rsp_in.col1 = rbdt_pkg::DW'($signed(cur_ff.rot[4'(srow) * 4'd3 + 4'd1]));
         rsp_in.col2 = rbdt_pkg::DW'($signed(cur_ff.rot[4'(srow) * 4'd3 + 4'd2]));
         rsp_in.col3 = cur_ff.pos[srow];
      end else begin
         rsp_in.col0 = sat[0];
         rsp_in.col1 = sat[1];
         rsp_in.col2 = sat[2];
         rsp_in.col3 = '0;
      end
   end

   // Keep T rows, drive the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= sd_valid_ff;
      end
      if (sd_valid_ff && sd_step_ff < rbdt_pkg::ROW_TENSOR) begin
         for (int b = 0; b < 3; b++) begin
            t_ff[4'(srow) * 4'd3 + 4'(b)] <= rsum[b][rbdt_pkg::TW-1:0];
         end
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef SYNTHESIS
   a_last_is_five: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.last_row |-> rsp_item.row_index == rbdt_pkg::ROW_LAST)
      else $error("last row flag on wrong row");
   a_rows_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.last_row |=>
         rsp_valid && rsp_item.row_index == $past(rsp_item.row_index) + 3'd1)
      else $error("rows of one item not back to back");
   a_pop_at_boundary: assert property (@(posedge clock) disable iff (reset)
      pop && act_ff |-> step_ff == rbdt_pkg::ROW_LAST)
      else $error("item taken before the current one finished");
   a_first_row_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.last_row |=> !rsp_valid || rsp_item.row_index == rbdt_pkg::ROW_FIRST)
      else $error("item does not start on row zero");
`endif

endmodule
`default_nettype wire

// ----- rtl/rigid_body_derived_transform.sv -----
// Top level of the rigid body derived transform: configuration registers, front end,
// queue and back end. Depends on rbdt_pkg, rbdt_front, rbdt_queue, rbdt_back.
//
//   channel   ports                              direction  handshake
//   request   start, busy, req_item              in         start && !busy
//   response  rsp_valid, rsp_item                out        rsp_valid, one cycle
//   config    csr_we, csr_index, csr_wdata       in         csr_we
//
// Each item yields six rows on consecutive cycles; the back end takes the next queued
// item in the last of the six steps of the current one, on its nine shared multipliers.
// An item passes the front register, queue, item, product and result registers.
// busy rises when the queued items plus the one in the front end fill QUEUE_DEPTH entries.
// Reset is synchronous; it empties the pipeline and loads the identity tensor.
// The receiver cannot stall: every row is presented for exactly one cycle.
`default_nettype none
module rigid_body_derived_transform #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire rbdt_pkg::req_type        req_item,
   output logic                          rsp_valid,
   output rbdt_pkg::rsp_type             rsp_item,
   input  wire logic                     csr_we,
   input  wire logic [2:0]               csr_index,
   input  wire logic [rbdt_pkg::DW-1:0]  csr_wdata
);

   logic [5:0][rbdt_pkg::DW-1:0] inertia_ff;
   logic                         take;
   logic                         push;
   rbdt_pkg::work_type           push_data;
   rbdt_pkg::work_type           head;
   rbdt_pkg::qstat_type          stat;
   logic                         pop;

   // Hold the body inverse inertia registers
   always_ff @(posedge clock) begin
      if (reset) begin
         inertia_ff[rbdt_pkg::CSR_XX] <= rbdt_pkg::INERTIA_ONE;
         inertia_ff[rbdt_pkg::CSR_XY] <= '0;
         inertia_ff[rbdt_pkg::CSR_XZ] <= '0;
         inertia_ff[rbdt_pkg::CSR_YY] <= rbdt_pkg::INERTIA_ONE;
         inertia_ff[rbdt_pkg::CSR_YZ] <= '0;
         inertia_ff[rbdt_pkg::CSR_ZZ] <= rbdt_pkg::INERTIA_ONE;
      end else if (csr_we) begin
         case (csr_index)
            rbdt_pkg::CSR_XX: inertia_ff[rbdt_pkg::CSR_XX] <= csr_wdata;
            rbdt_pkg::CSR_XY: inertia_ff[rbdt_pkg::CSR_XY] <= csr_wdata;
            rbdt_pkg::CSR_XZ: inertia_ff[rbdt_pkg::CSR_XZ] <= csr_wdata;
            rbdt_pkg::CSR_YY: inertia_ff[rbdt_pkg::CSR_YY] <= csr_wdata;
            rbdt_pkg::CSR_YZ: inertia_ff[rbdt_pkg::CSR_YZ] <= csr_wdata;
            rbdt_pkg::CSR_ZZ: inertia_ff[rbdt_pkg::CSR_ZZ] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Accept a beat while the queue has room for it
   assign busy = stat.no_room;
   assign take = start && !busy;

   rbdt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .item      (req_item),
      .push      (push),
      .push_data (push_data)
   );

   rbdt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .reserve   (push),
      .pop       (pop),
      .head      (head),
      .stat      (stat)
   );

   rbdt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .stat      (stat),
      .inertia   (inertia_ff),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule
`default_nettype wire

// ----- verif/rigid_body_derived_transform_tb.sv -----
// Testbench for rigid_body_derived_transform: drives quaternion/position beats,
// predicts the six rows of each beat and checks every row. Depends on rbdt_pkg.
`timescale 1ns / 100ps
`default_nettype none
module rigid_body_derived_transform_tb;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   rbdt_pkg::req_type req_item = '0;
   logic rsp_valid;
   rbdt_pkg::rsp_type rsp_item;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = '0;
   logic [rbdt_pkg::DW-1:0] csr_wdata = '0;

   rigid_body_derived_transform u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_item(rsp_item), .csr_we(csr_we),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // tensor copy, and queue of rows still to come
   logic signed [63:0] tensor_reg [6];
   rbdt_pkg::rsp_type rows_pending [$];
   int errors = 0;
   bit gaps_on = 1'b1;

   initial begin
      forever #4 clock = ~clock;
   end

   // round v / 2^s, ties toward plus infinity
   function automatic logic signed [63:0] round_sh(logic signed [63:0] v, int s);
      logic signed [63:0] t;
      t = v + (64'sd1 <<< (s - 1));
      return t >>> s;
   endfunction

   function automatic logic signed [63:0] clamp32(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // compute the six rows of one beat and queue them
   task automatic predict_rows(rbdt_pkg::req_type q);
      logic signed [63:0] r, i, j, k, acc;
      logic signed [63:0] e [3][3];
      logic signed [63:0] rot [3][3];
      logic signed [63:0] ib [3][3];
      logic signed [63:0] t [3][3];
      logic signed [63:0] p [3];
      logic signed [63:0] w [3];
      rbdt_pkg::rsp_type row;
      r = q.quat_r; i = q.quat_i; j = q.quat_j; k = q.quat_k;
      p[0] = q.pos_x; p[1] = q.pos_y; p[2] = q.pos_z;
      e[0][0] = (64'sd1 <<< 28) - 2*j*j - 2*k*k;
      e[0][1] = 2*i*j - 2*r*k;
      e[0][2] = 2*i*k + 2*r*j;
      e[1][0] = 2*i*j + 2*r*k;
      e[1][1] = (64'sd1 <<< 28) - 2*i*i - 2*k*k;
      e[1][2] = 2*j*k - 2*r*i;
      e[2][0] = 2*i*k - 2*r*j;
      e[2][1] = 2*j*k + 2*r*i;
      e[2][2] = (64'sd1 <<< 28) - 2*i*i - 2*j*j;
      for (int a = 0; a < 3; a++)
         for (int b = 0; b < 3; b++) rot[a][b] = clamp32(round_sh(e[a][b], 12));
      ib[0][0] = tensor_reg[rbdt_pkg::CSR_XX]; ib[0][1] = tensor_reg[rbdt_pkg::CSR_XY];
      ib[0][2] = tensor_reg[rbdt_pkg::CSR_XZ]; ib[1][0] = tensor_reg[rbdt_pkg::CSR_XY];
      ib[1][1] = tensor_reg[rbdt_pkg::CSR_YY]; ib[1][2] = tensor_reg[rbdt_pkg::CSR_YZ];
      ib[2][0] = tensor_reg[rbdt_pkg::CSR_XZ]; ib[2][1] = tensor_reg[rbdt_pkg::CSR_YZ];
      ib[2][2] = tensor_reg[rbdt_pkg::CSR_ZZ];
      for (int a = 0; a < 3; a++)
         for (int b = 0; b < 3; b++) begin
            acc = 0;
            for (int c = 0; c < 3; c++) acc += rot[a][c] * ib[c][b];
            t[a][b] = round_sh(acc, 16);
         end
      for (int a = 0; a < 3; a++) begin
         row.row_index = 3'(a);
         row.col0 = rot[a][0][31:0]; row.col1 = rot[a][1][31:0];
         row.col2 = rot[a][2][31:0]; row.col3 = p[a][31:0];
         row.last_row = 1'b0;
         rows_pending.push_back(row);
      end
      for (int a = 0; a < 3; a++) begin
         for (int b = 0; b < 3; b++) begin
            acc = 0;
            for (int c = 0; c < 3; c++) acc += t[a][c] * rot[b][c];
            w[b] = clamp32(round_sh(acc, 16));
         end
         row.row_index = 3'(a + 3);
         row.col0 = w[0][31:0]; row.col1 = w[1][31:0]; row.col2 = w[2][31:0];
         row.col3 = '0;
         row.last_row = (a == 2);
         rows_pending.push_back(row);
      end
   endtask

   // send one beat, with an optional random gap first; start stays high for the next beat
   task automatic send_item(rbdt_pkg::req_type q);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      start <= 1'b1;
      req_item <= q;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_rows(q);
   endtask

   // drop start, drain, then write one register while idle
   task automatic write_reg(rbdt_pkg::csr_index_type idx, logic [31:0] v);
      start <= 1'b0;
      while (rows_pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      tensor_reg[idx] = $signed(v);
   endtask

   function automatic rbdt_pkg::req_type rand_item(bit unit);
      rbdt_pkg::req_type q;
      logic [31:0] bits;
      bits = $urandom;
      q.pos_x = $urandom; q.pos_y = $urandom; q.pos_z = $urandom;
      if (unit) begin
         // random quaternion of length near one
         real a, b, c, d, n;
         a = $urandom_range(0, 2000) - 1000.0; b = $urandom_range(0, 2000) - 1000.0;
         c = $urandom_range(0, 2000) - 1000.0; d = $urandom_range(0, 2000) - 1000.0;
         n = $sqrt(a*a + b*b + c*c + d*d) + 1.0;
         q.quat_r = 16'($rtoi(a / n * 16384.0)); q.quat_i = 16'($rtoi(b / n * 16384.0));
         q.quat_j = 16'($rtoi(c / n * 16384.0)); q.quat_k = 16'($rtoi(d / n * 16384.0));
      end else begin
         q.quat_r = bits[15:0]; q.quat_i = bits[31:16];
         q.quat_j = 16'($urandom); q.quat_k = 16'($urandom);
      end
      return q;
   endfunction

   // check each row against the oldest prediction
   always @(posedge clock) begin
      rbdt_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (rows_pending.size() == 0) begin
            $display("%0t: unexpected row %p", $time, rsp_item);
            errors++;
         end else begin
            want = rows_pending.pop_front();
            if (rsp_item !== want) begin
               $display("%0t: row mismatch expected %p actual %p", $time, want, rsp_item);
               errors++;
            end
         end
      end
   end

   task automatic test_directed();
      rbdt_pkg::req_type q;
      q = '0; q.quat_r = 16'sd16384; send_item(q);
      q.pos_x = 32'h7FFF_FFFF; q.pos_y = 32'h8000_0000; q.pos_z = 32'hFFFF_FFFF;
      send_item(q);
      q = '0; q.quat_i = 16'sd16384; send_item(q);
      q = '0; q.quat_j = 16'sd16384; send_item(q);
      q = '0; q.quat_k = -16'sd16384; send_item(q);
      q = '0; q.quat_r = 16'h7FFF; q.quat_i = 16'h7FFF; q.quat_j = 16'h7FFF;
      q.quat_k = 16'h7FFF; send_item(q);
      q.quat_r = 16'h8000; q.quat_i = 16'h8000; q.quat_j = 16'h8000;
      q.quat_k = 16'h8000; send_item(q);
      q.quat_r = 16'h8000; q.quat_i = 16'h7FFF; q.quat_j = 16'h0; q.quat_k = 16'h8000;
      send_item(q);
      q = '0; q.quat_r = 16'sd11585; q.quat_k = 16'sd11585; send_item(q);
   endtask

   task automatic test_tensor_extremes();
      write_reg(rbdt_pkg::CSR_XX, 32'h7FFF_FFFF); write_reg(rbdt_pkg::CSR_XY, 32'h8000_0000);
      write_reg(rbdt_pkg::CSR_XZ, 32'h7FFF_FFFF); write_reg(rbdt_pkg::CSR_YY, 32'h8000_0000);
      write_reg(rbdt_pkg::CSR_YZ, 32'h7FFF_FFFF); write_reg(rbdt_pkg::CSR_ZZ, 32'h8000_0000);
      for (int n = 0; n < 4; n++) send_item(rand_item(n[0]));
      test_directed();
   endtask

   task automatic test_random(int count);
      for (int n = 0; n < count; n++) begin
         if (n % 60 == 0) begin
            // pick a new tensor: mostly modest, sometimes wide
            for (int x = 0; x < 6; x++)
               write_reg(rbdt_pkg::csr_index_type'(x),
                         ($urandom_range(0, 3) == 0) ? $urandom :
                         32'($signed($urandom_range(0, 400000)) - 200000));
         end
         send_item(rand_item($urandom_range(0, 4) != 0));
      end
   endtask

   initial begin
      tensor_reg[rbdt_pkg::CSR_XX] = 65536; tensor_reg[rbdt_pkg::CSR_XY] = 0;
      tensor_reg[rbdt_pkg::CSR_XZ] = 0;     tensor_reg[rbdt_pkg::CSR_YY] = 65536;
      tensor_reg[rbdt_pkg::CSR_YZ] = 0;     tensor_reg[rbdt_pkg::CSR_ZZ] = 65536;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_tensor_extremes();
      test_random(420);
      gaps_on = 1'b0;
      test_random(80);
      start <= 1'b0;
      while (rows_pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) $display("rigid_body_derived_transform_tb: done, clean");
      else $display("rigid_body_derived_transform_tb: done, errors");
      $finish;
   end

   // hard stop
   initial begin
      #2_000_000;
      $display("rigid_body_derived_transform_tb: done, errors");
      $finish;
   end
endmodule
`default_nettype wire
